[rtl/core/bhv_pkg.sv]
package bhv_pkg;

  localparam int unsigned HEADER_BYTES = 108;
  localparam int unsigned CRC_END = 104;
  localparam int unsigned IDX_W = $clog2(HEADER_BYTES);
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [1:0] LANG_FIRST = 2'd0;
  localparam logic [1:0] LANG_BODY  = 2'd1;
  localparam logic [1:0] LANG_PAD   = 2'd2;
  localparam logic [1:0] LANG_BAD   = 2'd3;

  localparam logic [2:0] REG_FORMAT_VERSION = 3'd0;
  localparam logic [2:0] REG_MAX_SPINE      = 3'd1;
  localparam logic [2:0] REG_MAX_SHARD      = 3'd2;
  localparam logic [2:0] REG_MAX_SREC       = 3'd3;
  localparam logic [2:0] REG_MAX_LEMMA      = 3'd4;
  localparam logic [2:0] REG_MAX_SURF       = 3'd5;
  localparam logic [2:0] REG_MAX_FSIZE      = 3'd6;
  localparam logic [2:0] REG_RECORD_SIZES   = 3'd7;

  localparam logic [3:0] ERR_OK       = 4'd0;
  localparam logic [3:0] ERR_TRUNC    = 4'd1;
  localparam logic [3:0] ERR_MAGIC    = 4'd2;
  localparam logic [3:0] ERR_VERSION  = 4'd3;
  localparam logic [3:0] ERR_HSIZE    = 4'd4;
  localparam logic [3:0] ERR_HCRC     = 4'd5;
  localparam logic [3:0] ERR_FLAGS    = 4'd6;
  localparam logic [3:0] ERR_RESV     = 4'd7;
  localparam logic [3:0] ERR_UUID     = 4'd8;
  localparam logic [3:0] ERR_LANG     = 4'd9;
  localparam logic [3:0] ERR_COUNT    = 4'd10;
  localparam logic [3:0] ERR_FRANGE   = 4'd11;
  localparam logic [3:0] ERR_FMATCH   = 4'd12;
  localparam logic [3:0] ERR_ALIGN    = 4'd13;
  localparam logic [3:0] ERR_ORDER    = 4'd14;
  localparam logic [3:0] ERR_TABLE    = 4'd15;

  typedef struct packed {
    logic [15:0] format_version;
    logic [15:0] max_spine;
    logic [31:0] max_shard;
    logic [31:0] max_srec;
    logic [31:0] max_lemma;
    logic [31:0] max_surf;
    logic [31:0] max_fsize;
  } cfg_t;

  typedef struct packed {
    logic trunc;
    logic magic;
    logic ver;
    logic hsize;
    logic hcrc;
    logic flags;
    logic resv;
    logic uuid;
    logic lang;
    logic count;
    logic frange;
    logic fmatch;
    logic align;
    logic order;
    logic [15:0] spine;
    logic [31:0] shards;
    logic [31:0] srecs;
    logic [31:0] lemmas;
    logic [31:0] surfs;
    logic [31:0] fsize;
    logic [31:0] pcrc;
    logic [5:0][31:0] off;
  } chk_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic is_letter(input logic [7:0] v);
    return (v >= 8'h41 && v <= 8'h5A) || (v >= 8'h61 && v <= 8'h7A);
  endfunction

  function automatic logic [1:0] lang_next(input logic [1:0] st, input logic first,
                                           input logic [7:0] v);
    logic [1:0] r;
    r = LANG_BAD;
    if (first) begin
      r = is_letter(v) ? LANG_BODY : LANG_BAD;
    end else if (st == LANG_BODY) begin
      if (v == 8'd0) begin
        r = LANG_PAD;
      end else if (is_letter(v) || v == 8'h2D || (v >= 8'h30 && v <= 8'h39)) begin
        r = LANG_BODY;
      end
    end else if (st == LANG_PAD) begin
      r = (v == 8'd0) ? LANG_PAD : LANG_BAD;
    end
    return r;
  endfunction

endpackage

[rtl/core/bhv_front.sv]
module bhv_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  logic [7:0]     byte_i,
  input  logic           last_i,
  input  logic [32:0]    actual_i,
  input  bhv_pkg::cfg_t  cfg_i,
  output bhv_pkg::chk_t  chk_o
);
  import bhv_pkg::*;

  logic [7:0]  store_q [HEADER_BYTES];
  logic [7:0]  m [HEADER_BYTES];
  logic [7:0]  pos_q, pos_d, pos_n;
  logic [31:0] crc_q, crc_d, crc_n;
  logic [1:0]  src_q, src_d, src_n, tgt_q, tgt_d, tgt_n;
  logic        in_hdr, in_src, in_tgt;
  logic [15:0] hsize;
  logic [31:0] offs [7];
  logic        uuid_any, align_any, order_any;

  assign in_hdr = pos_q < 8'(HEADER_BYTES);
  assign in_src = pos_q >= 8'd32 && pos_q < 8'd40;
  assign in_tgt = pos_q >= 8'd40 && pos_q < 8'd48;

  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      m[i] = (in_hdr && pos_q == 8'(i)) ? byte_i : store_q[i];
    end
  end

  function automatic logic [31:0] rd32(input int unsigned o);
    return {m[o + 3], m[o + 2], m[o + 1], m[o]};
  endfunction

  assign pos_n = in_hdr ? pos_q + 8'd1 : pos_q;
  assign crc_n = (pos_q < 8'(CRC_END)) ? crc_byte(crc_q, byte_i) : crc_q;
  assign src_n = in_src ? lang_next(src_q, pos_q == 8'd32, byte_i) : src_q;
  assign tgt_n = in_tgt ? lang_next(tgt_q, pos_q == 8'd40, byte_i) : tgt_q;

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    src_d = src_q;
    tgt_d = tgt_q;
    if (fire_i) begin
      if (last_i) begin
        pos_d = '0;
        crc_d = '1;
        src_d = LANG_FIRST;
        tgt_d = LANG_FIRST;
      end else begin
        pos_d = pos_n;
        crc_d = crc_n;
        src_d = src_n;
        tgt_d = tgt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '1;
      src_q <= LANG_FIRST;
      tgt_q <= LANG_FIRST;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      src_q <= src_d;
      tgt_q <= tgt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && in_hdr) begin
      store_q[pos_q[IDX_W-1:0]] <= byte_i;
    end
  end

  assign hsize = {m[7], m[6]};

  always_comb begin
    uuid_any = 1'b0;
    for (int i = 16; i < 32; i++) begin
      uuid_any = uuid_any | (m[i] != 8'd0);
    end
    align_any = 1'b0;
    for (int i = 0; i < 7; i++) begin
      offs[i] = rd32(68 + 4 * i);
      align_any = align_any | (offs[i][1:0] != 2'd0);
    end
    order_any = offs[0] < {16'd0, hsize};
    for (int i = 1; i < 7; i++) begin
      order_any = order_any | (offs[i] < offs[i-1]);
    end
  end

  always_comb begin
    chk_o.trunc  = pos_n < 8'(HEADER_BYTES);
    chk_o.magic  = !(m[0] == 8'h43 && m[1] == 8'h58 && m[2] == 8'h4C && m[3] == 8'h47);
    chk_o.ver    = {m[5], m[4]} != cfg_i.format_version;
    chk_o.hsize  = hsize != 16'(HEADER_BYTES);
    chk_o.hcrc   = ~crc_n != rd32(CRC_END);
    chk_o.flags  = rd32(8) != 32'd0;
    chk_o.resv   = {m[51], m[50]} != 16'd0;
    chk_o.uuid   = !uuid_any;
    chk_o.lang   = src_n != LANG_PAD || tgt_n != LANG_PAD;
    chk_o.spine  = {m[49], m[48]};
    chk_o.shards = rd32(52);
    chk_o.srecs  = rd32(56);
    chk_o.lemmas = rd32(60);
    chk_o.surfs  = rd32(64);
    chk_o.fsize  = rd32(96);
    chk_o.pcrc   = rd32(100);
    chk_o.count  = chk_o.spine == 16'd0 || chk_o.spine > cfg_i.max_spine ||
                   chk_o.shards > cfg_i.max_shard || chk_o.srecs > cfg_i.max_srec ||
                   chk_o.lemmas > cfg_i.max_lemma || chk_o.surfs > cfg_i.max_surf;
    chk_o.frange = chk_o.fsize < 32'(HEADER_BYTES) || chk_o.fsize > cfg_i.max_fsize;
    chk_o.fmatch = actual_i != {1'b0, chk_o.fsize};
    chk_o.align  = align_any;
    chk_o.order  = order_any || chk_o.fsize < offs[6];
    for (int i = 0; i < 6; i++) begin
      chk_o.off[i] = offs[i];
    end
  end

endmodule

[rtl/core/binary_header_validator_unit.sv]
// Header validator. Header bytes enter one per transaction on the s_axis channel,
// in file order, with tlast on the final byte and the real file size in tdata
// beside each byte (only the copy sent with tlast is used). For every byte that
// carries tlast one verdict leaves on the m_axis channel: an error code, zero for
// a good header, followed by the parsed counts, declared file size and payload CRC.
// Bytes without tlast produce no transaction on the output.
// Throughput is one byte per cycle while s_axis_tready stays high. A verdict passes
// from the transaction that carried tlast through an input register, a check stage,
// a stage that forms the five table products, and the output register that
// evaluates table bounds and picks the first failing check. When the receiver
// stalls, the verdict waits in the output register and the stages behind it keep
// accepting bytes while they hold up to two more verdicts; s_axis_tready falls only
// when a fourth verdict would have to wait too. Reset clears the byte counter, CRC
// and language checkers, empties the pipeline and loads the register defaults.
// Registers are written through the cfg port and kept across headers; the user must
// write them only while no header is in flight; the block does not enforce this.
module binary_header_validator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // hdr_byte[7:0], actual_file_size[40:8], zero fill
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [215:0] m_axis_tdata,   // error_code, spine_count, shard_count,
                                       // shard_record_count, lemma_count,
                                       // surface_count, file_size, payload_crc, zero fill
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [39:0]  cfg_wdata_i
);
  import bhv_pkg::*;

  cfg_t        cfg_q;
  logic [39:0] rsz_q;

  logic        a_v_q, a_last_q, a_fire;
  logic [7:0]  a_byte_q;
  logic [32:0] a_act_q;
  chk_t        a_chk;

  logic        b_v_q, b_mv, c_free;
  chk_t        b_chk_q;
  logic        c_v_q, c_mv, o_free;
  chk_t        c_chk_q;
  logic [39:0] c_p_q [5];
  logic [39:0] p_d [5];
  logic [31:0] cnt [5];
  logic [31:0] nxt [5];
  logic        tbl_bad;
  logic [3:0]  code;

  logic         o_v_q;
  logic [215:0] o_data_q, o_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format_version <= 16'd1;
      cfg_q.max_spine      <= 16'hFFFF;
      cfg_q.max_shard      <= '1;
      cfg_q.max_srec       <= '1;
      cfg_q.max_lemma      <= '1;
      cfg_q.max_surf       <= '1;
      cfg_q.max_fsize      <= '1;
      rsz_q                <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FORMAT_VERSION: cfg_q.format_version <= cfg_wdata_i[15:0];
        REG_MAX_SPINE:      cfg_q.max_spine      <= cfg_wdata_i[15:0];
        REG_MAX_SHARD:      cfg_q.max_shard      <= cfg_wdata_i[31:0];
        REG_MAX_SREC:       cfg_q.max_srec       <= cfg_wdata_i[31:0];
        REG_MAX_LEMMA:      cfg_q.max_lemma      <= cfg_wdata_i[31:0];
        REG_MAX_SURF:       cfg_q.max_surf       <= cfg_wdata_i[31:0];
        REG_MAX_FSIZE:      cfg_q.max_fsize      <= cfg_wdata_i[31:0];
        REG_RECORD_SIZES:   rsz_q                <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign o_free = !o_v_q || m_axis_tready;
  assign c_mv   = c_v_q && o_free;
  assign c_free = !c_v_q || o_free;
  assign b_mv   = b_v_q && c_free;
  assign a_fire = a_v_q && (!a_last_q || !b_v_q || c_free);
  assign s_axis_tready = !a_v_q || a_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      a_v_q <= (s_axis_tvalid && s_axis_tready) || (a_v_q && !a_fire);
      b_v_q <= (a_fire && a_last_q) || (b_v_q && !c_free);
      c_v_q <= b_mv || (c_v_q && !o_free);
      o_v_q <= c_mv || (o_v_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_byte_q <= s_axis_tdata[7:0];
      a_act_q  <= s_axis_tdata[40:8];
      a_last_q <= s_axis_tlast;
    end
  end

  bhv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (a_fire),
    .byte_i   (a_byte_q),
    .last_i   (a_last_q),
    .actual_i (a_act_q),
    .cfg_i    (cfg_q),
    .chk_o    (a_chk)
  );

  always_ff @(posedge clk_i) begin
    if (a_fire && a_last_q) begin
      b_chk_q <= a_chk;
    end
  end

  always_comb begin
    cnt[0] = {16'd0, b_chk_q.spine};
    cnt[1] = b_chk_q.shards;
    cnt[2] = b_chk_q.srecs;
    cnt[3] = b_chk_q.lemmas;
    cnt[4] = b_chk_q.lemmas;
    for (int k = 0; k < 5; k++) begin
      p_d[k] = 40'(cnt[k]) * 40'(rsz_q[8*k +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_mv) begin
      c_chk_q <= b_chk_q;
      for (int k = 0; k < 5; k++) begin
        c_p_q[k] <= p_d[k];
      end
    end
  end

  always_comb begin
    tbl_bad = 1'b0;
    for (int k = 0; k < 5; k++) begin
      nxt[k] = c_chk_q.off[k+1];
      tbl_bad = tbl_bad || (c_p_q[k][39:32] != 8'd0) ||
                ((41'(c_chk_q.off[k]) + 41'(c_p_q[k])) > 41'(nxt[k]));
    end
    if (c_chk_q.trunc)       code = ERR_TRUNC;
    else if (c_chk_q.magic)  code = ERR_MAGIC;
    else if (c_chk_q.ver)    code = ERR_VERSION;
    else if (c_chk_q.hsize)  code = ERR_HSIZE;
    else if (c_chk_q.hcrc)   code = ERR_HCRC;
    else if (c_chk_q.flags)  code = ERR_FLAGS;
    else if (c_chk_q.resv)   code = ERR_RESV;
    else if (c_chk_q.uuid)   code = ERR_UUID;
    else if (c_chk_q.lang)   code = ERR_LANG;
    else if (c_chk_q.count)  code = ERR_COUNT;
    else if (c_chk_q.frange) code = ERR_FRANGE;
    else if (c_chk_q.fmatch) code = ERR_FMATCH;
    else if (c_chk_q.align)  code = ERR_ALIGN;
    else if (c_chk_q.order)  code = ERR_ORDER;
    else if (tbl_bad)        code = ERR_TABLE;
    else                     code = ERR_OK;
    o_data_d = '0;
    o_data_d[3:0] = code;
    if (!(c_chk_q.trunc || c_chk_q.magic)) begin
      o_data_d[19:4]    = c_chk_q.spine;
      o_data_d[51:20]   = c_chk_q.shards;
      o_data_d[83:52]   = c_chk_q.srecs;
      o_data_d[115:84]  = c_chk_q.lemmas;
      o_data_d[147:116] = c_chk_q.surfs;
      o_data_d[179:148] = c_chk_q.fsize;
      o_data_d[211:180] = c_chk_q.pcrc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_mv) begin
      o_data_q <= o_data_d;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = o_data_q;

endmodule

[rtl/core/bhv_checker.sv]
module bhv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [215:0] m_axis_tdata
);
  import bhv_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("verdict dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:0] == ERR_TRUNC || m_axis_tdata[3:0] == ERR_MAGIC)
    |-> m_axis_tdata[215:4] == '0)
    else $error("fields not cleared on truncated or bad magic header");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] == ERR_OK
    |-> m_axis_tdata[179:148] >= 32'(HEADER_BYTES) && m_axis_tdata[19:4] != 16'd0)
    else $error("good verdict with impossible fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] != ERR_TRUNC && m_axis_tdata[3:0] != ERR_MAGIC
    |-> m_axis_tdata[215:212] == 4'd0)
    else $error("fill bits set");

  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind binary_header_validator_unit bhv_checker u_bhv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
